FILE: hw/rtl/frht_pkg.sv
// Shared constants, register codes and types of the failure-risk hash table.
package frht_pkg;

  // Field widths.
  localparam int KEY_W  = 64;
  localparam int CNT_W  = 32;
  localparam int RISK_W = 16;
  localparam int CR_W   = CNT_W + RISK_W;

  // Default table size.
  localparam int TABLE_ENTRIES_DEF = 256;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_RISK_STEP = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RISK_CEIL = 1'b1;

  // Register reset values, Q0.16.
  localparam logic [RISK_W-1:0] RISK_STEP_RST = 16'd6554;
  localparam logic [RISK_W-1:0] RISK_CEIL_RST = 16'd32768;

  // Configuration handed from the register block to the core.
  typedef struct packed {
    logic [RISK_W-1:0] risk_step;
    logic [RISK_W-1:0] risk_ceiling;
  } cfg_t;

endpackage

FILE: hw/rtl/frht_if.sv
// Valid/ready channel interfaces for commands and responses.
interface frht_cmd_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [frht_pkg::KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface frht_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [frht_pkg::RISK_W-1:0] risk_level;
  logic [frht_pkg::CNT_W-1:0]  failure_count;
  logic                        key_found;
  logic                        table_full;

  modport source (output valid, output risk_level, output failure_count,
                  output key_found, output table_full, input ready);
  modport sink   (input valid, input risk_level, input failure_count,
                  input key_found, input table_full, output ready);
endinterface

FILE: hw/rtl/frht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module frht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/frht_regs.sv
// APB-style configuration registers of the failure-risk hash table.
module frht_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [frht_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [frht_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [frht_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output frht_pkg::cfg_t                      cfg
);

  logic [frht_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[frht_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.risk_step    <= frht_pkg::RISK_STEP_RST;
      cfg.risk_ceiling <= frht_pkg::RISK_CEIL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        frht_pkg::REG_RISK_STEP: cfg.risk_step    <= pwdata[frht_pkg::RISK_W-1:0];
        frht_pkg::REG_RISK_CEIL: cfg.risk_ceiling <= pwdata[frht_pkg::RISK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      frht_pkg::REG_RISK_STEP:
        prdata = {{(frht_pkg::APB_DATA_W-frht_pkg::RISK_W){1'b0}}, cfg.risk_step};
      frht_pkg::REG_RISK_CEIL:
        prdata = {{(frht_pkg::APB_DATA_W-frht_pkg::RISK_W){1'b0}}, cfg.risk_ceiling};
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/failure_risk_hash_table_core.sv
// Failure-risk hash table: linear-probing table of per-key failure counts and risk.
//
// After reset the block clears every slot of the count store and takes no command
// meanwhile (configuration writes work throughout). A command is then handled one at a
// time: the probe walk reads one slot per cycle from the count/risk and key memories and
// probes from 1 to TABLE_ENTRIES slots before a query or a claim of a new slot registers
// its response beat; a record that hits an existing key goes on through the risk
// multiply and the write-back. When TABLE_ENTRIES is not a power of two, the start slot
// comes from a remainder of the key taken 16 bits at a time by reciprocal
// multiplication. The next command is accepted the cycle after the response is
// registered, even while that beat still waits on rsp.ready.
module failure_risk_hash_table_core #(
  parameter int TABLE_ENTRIES = frht_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  frht_cmd_if.sink                        cmd,
  frht_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frht_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [frht_pkg::APB_DATA_W-1:0] pwdata,
  output logic [frht_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam int KEY_W  = frht_pkg::KEY_W;
  localparam int CNT_W  = frht_pkg::CNT_W;
  localparam int RISK_W = frht_pkg::RISK_W;
  localparam int CR_W   = frht_pkg::CR_W;
  localparam int PROD_W = CNT_W + RISK_W;

  // Key remainder by reciprocal multiplication, one 16-bit digit per step.
  localparam int MOD_DIG_W  = 16;
  localparam int MOD_DIGITS = KEY_W / MOD_DIG_W;
  localparam int MOD_X_W    = 2 * MOD_DIG_W;
  localparam int MOD_P_W    = 2 * MOD_X_W + 1;
  localparam int MOD_SH     = MOD_X_W + IDX_W;
  localparam logic [63:0] MOD_M_FULL =
    ((64'd1 << MOD_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [MOD_X_W:0]   MOD_M = MOD_M_FULL[MOD_X_W:0];
  localparam logic [MOD_X_W-1:0] N_X   = MOD_X_W'(TABLE_ENTRIES);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  frht_pkg::cfg_t cfg;

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  pcnt;
  logic [IDX_W-1:0]  clr_idx;
  logic [1:0]        mod_cnt;
  logic              mod_ph;
  logic [MOD_X_W-1:0] mod_x;
  logic [MOD_X_W-1:0] mod_q;
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  cnt_new;
  logic [RISK_W-1:0] risk_old;
  logic [PROD_W-1:0] prod;

  logic [RISK_W-1:0] res_risk;
  logic [CNT_W-1:0]  res_count;
  logic              res_found;
  logic              res_full;

  logic              rsp_valid;
  logic [RISK_W-1:0] rsp_risk;
  logic [CNT_W-1:0]  rsp_count;
  logic              rsp_found;
  logic              rsp_full;

  logic              cmd_fire;
  logic [KEY_W-1:0]  key_rd;
  logic [CR_W-1:0]   cr_rd;
  logic [CNT_W-1:0]  cnt_rd;
  logic [RISK_W-1:0] risk_rd;
  logic              slot_empty;
  logic              slot_hit;
  logic [MOD_P_W-1:0]   mod_prod;
  logic [MOD_X_W-1:0]   mod_quo;
  logic [MOD_X_W-1:0]   mod_back;
  logic [IDX_W-1:0]     mod_rem;
  logic [1:0]           mod_dig;
  logic [MOD_DIG_W-1:0] mod_digit;
  logic [IDX_W-1:0]  idx_inc;
  logic [RISK_W-1:0] risk_clamp;
  logic [RISK_W-1:0] risk_new;
  logic              key_we;
  logic              cr_we;
  logic [CR_W-1:0]   cr_wdata;
  logic [IDX_W-1:0]  waddr;

  // Configuration registers.
  frht_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Slot memories; the read address is the next probe slot.
  frht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_q),
    .raddr (idx_next),
    .rdata (key_rd)
  );

  frht_ram #(.WIDTH(CR_W), .DEPTH(TABLE_ENTRIES)) u_cr_ram (
    .clk   (clk),
    .we    (cr_we),
    .waddr (waddr),
    .wdata (cr_wdata),
    .raddr (idx_next),
    .rdata (cr_rd)
  );

  assign cnt_rd  = cr_rd[CR_W-1:RISK_W];
  assign risk_rd = cr_rd[RISK_W-1:0];

  // Slot decode of the probe in progress.
  assign slot_empty = (cnt_rd == '0);
  assign slot_hit   = !slot_empty && (key_rd == key_q);
  assign idx_inc    = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  // Remainder step: the quotient from the reciprocal product is registered first,
  // then the remainder comes from the back-multiply and subtract in the next.
  assign mod_prod  = MOD_P_W'(mod_x) * MOD_P_W'(MOD_M);
  assign mod_quo   = MOD_X_W'(mod_prod >> MOD_SH);
  assign mod_back  = mod_x - mod_q * N_X;
  assign mod_rem   = mod_back[IDX_W-1:0];
  assign mod_dig   = mod_cnt - 1'b1;
  assign mod_digit = key_q[{mod_dig, 4'b0000} +: MOD_DIG_W];

  // Risk clamp to the ceiling, never lowered.
  assign risk_clamp = (prod > PROD_W'(cfg.risk_ceiling)) ? cfg.risk_ceiling
                                                         : prod[RISK_W-1:0];
  assign risk_new   = (risk_clamp > risk_old) ? risk_clamp : risk_old;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);

  // Memory writes: clearing pass, slot claim, record update.
  assign key_we = (state == ST_CHECK) && slot_empty && op_q;
  assign cr_we  = (state == ST_CLEAR) || key_we || (state == ST_UPD);
  assign waddr  = (state == ST_CLEAR) ? clr_idx : idx;
  always_comb begin
    if (state == ST_CLEAR) begin
      cr_wdata = '0;
    end else if (state == ST_UPD) begin
      cr_wdata = {cnt_new, risk_new};
    end else begin
      cr_wdata = {CNT_W'(1), cfg.risk_step};
    end
  end

  // Sequencer next state and probe address.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_fire) begin
          if (IS_POW2) begin
            idx_next   = cmd.key[IDX_W-1:0];
            state_next = ST_CHECK;
          end else begin
            state_next = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_ph && mod_cnt == '0) begin
          idx_next   = mod_rem;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (slot_empty) begin
          state_next = ST_DONE;
        end else if (slot_hit) begin
          state_next = op_q ? ST_MUL : ST_DONE;
        end else if (pcnt == LAST_IDX) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx_inc;
        end
      end
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      idx     <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_q    <= cmd.operation;
      key_q   <= cmd.key;
      mod_x   <= MOD_X_W'(cmd.key[KEY_W-1 -: MOD_DIG_W]);
      mod_cnt <= 2'(MOD_DIGITS - 1);
      mod_ph  <= 1'b0;
      pcnt    <= '0;
    end
    if (state == ST_MOD) begin
      if (!mod_ph) begin
        mod_q  <= mod_quo;
        mod_ph <= 1'b1;
      end else begin
        mod_x   <= {MOD_DIG_W'(mod_rem), mod_digit};
        mod_cnt <= mod_cnt - 1'b1;
        mod_ph  <= 1'b0;
      end
    end
    if (state == ST_CHECK) begin
      pcnt     <= pcnt + 1'b1;
      cnt_new  <= (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
      risk_old <= risk_rd;
      if (slot_empty) begin
        res_risk  <= op_q ? cfg.risk_step : '0;
        res_count <= op_q ? CNT_W'(1) : '0;
        res_found <= op_q;
        res_full  <= 1'b0;
      end else if (slot_hit) begin
        res_risk  <= risk_rd;
        res_count <= cnt_rd;
        res_found <= 1'b1;
        res_full  <= 1'b0;
      end else begin
        res_risk  <= '0;
        res_count <= '0;
        res_found <= 1'b0;
        res_full  <= op_q;
      end
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(cfg.risk_step) * PROD_W'(cnt_new);
    end
    if (state == ST_UPD) begin
      res_risk  <= risk_new;
      res_count <= cnt_new;
    end
  end

  // Response register; a beat waits here while the next command is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_risk  <= res_risk;
      rsp_count <= res_count;
      rsp_found <= res_found;
      rsp_full  <= res_full;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.risk_level    = rsp_risk;
  assign rsp.failure_count = rsp_count;
  assign rsp.key_found     = rsp_found;
  assign rsp.table_full    = rsp_full;

  // A new beat only comes out of the result state.
  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("response beat raised outside the result state");

  // A full table never reports the key as present.
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_full && rsp_found))
    else $error("table_full and key_found both set");

  // A found key always carries a nonzero count.
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_found) |-> (rsp_count != '0))
    else $error("key found with zero failure count");

  // No command is taken during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !$past(cmd_fire))
    else $error("command accepted while clearing");

endmodule

FILE: verif/tb.sv
// Self-checking testbench of the failure-risk hash table: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb;

  localparam int ENTRIES    = frht_pkg::TABLE_ENTRIES_DEF;
  localparam int KEY_W      = frht_pkg::KEY_W;
  localparam int CNT_W      = frht_pkg::CNT_W;
  localparam int RISK_W     = frht_pkg::RISK_W;
  localparam int APB_ADDR_W = frht_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = frht_pkg::APB_DATA_W;
  localparam int REG_IDX_W  = frht_pkg::REG_IDX_W;
  localparam logic [REG_IDX_W-1:0] REG_RISK_STEP = frht_pkg::REG_RISK_STEP;
  localparam logic [REG_IDX_W-1:0] REG_RISK_CEIL = frht_pkg::REG_RISK_CEIL;
  localparam logic [RISK_W-1:0]    RISK_STEP_RST = frht_pkg::RISK_STEP_RST;
  localparam logic [RISK_W-1:0]    RISK_CEIL_RST = frht_pkg::RISK_CEIL_RST;

  // Command operation codes.
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // One response beat as the table reports it.
  typedef struct packed {
    logic [RISK_W-1:0] risk_level;
    logic [CNT_W-1:0]  failure_count;
    logic              key_found;
    logic              table_full;
  } risk_report_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // One row of the directed stimulus: a command, or new values for both registers.
  typedef struct packed {
    row_kind_t         kind;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic              typed;
    risk_report_t      want;
    logic [RISK_W-1:0] step;
    logic [RISK_W-1:0] ceil;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  frht_cmd_if cmd_ch ();
  frht_rsp_if rsp_ch ();

  failure_risk_hash_table_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the table and its registers.
  logic [KEY_W-1:0]  slot_key_q   [ENTRIES];
  logic [CNT_W-1:0]  slot_count_q [ENTRIES];
  logic [RISK_W-1:0] slot_risk_q  [ENTRIES];
  logic [RISK_W-1:0] risk_step_q;
  logic [RISK_W-1:0] risk_ceil_q;
  logic [KEY_W-1:0]  stored_keys [$];

  risk_report_t reports_due [$];
  stim_row_t    directed_rows [$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_idle_pct;

  // Clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic risk_report_t report(input logic [RISK_W-1:0] risk,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic found, input logic full);
    risk_report_t rep;
    rep.risk_level    = risk;
    rep.failure_count = cnt;
    rep.key_found     = found;
    rep.table_full    = full;
    return rep;
  endfunction

  function automatic stim_row_t cmd_row(input logic op, input logic [KEY_W-1:0] key,
                                        input logic typed, input risk_report_t want);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_CMD;
    row.op    = op;
    row.key   = key;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [RISK_W-1:0] step,
                                        input logic [RISK_W-1:0] ceil);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.step = step;
    row.ceil = ceil;
    return row;
  endfunction

  // Probe the shadow table for one command, apply it, and return the response it must give.
  function automatic risk_report_t apply_to_table(input logic op, input logic [KEY_W-1:0] key);
    risk_report_t rep;
    int slot;
    int n;
    bit landed;
    bit vacant;
    logic [CNT_W+RISK_W-1:0] prod;
    rep    = '0;
    landed = 1'b0;
    vacant = 1'b0;
    slot   = 0;
    for (n = 0; n < ENTRIES && !landed; n++) begin
      slot = (int'(key % 64'(ENTRIES)) + n) % ENTRIES;
      if (slot_count_q[slot] == '0) begin
        landed = 1'b1;
        vacant = 1'b1;
      end else if (slot_key_q[slot] == key) begin
        landed = 1'b1;
      end
    end
    if (op == OP_QUERY) begin
      if (landed && !vacant) begin
        rep = report(slot_risk_q[slot], slot_count_q[slot], 1'b1, 1'b0);
      end
    end else if (!landed) begin
      rep.table_full = 1'b1;
    end else begin
      if (vacant) begin
        // A new slot starts at one step of risk, even above the ceiling.
        slot_key_q[slot]   = key;
        slot_count_q[slot] = 1;
        slot_risk_q[slot]  = risk_step_q;
        stored_keys.push_back(key);
      end else begin
        // The count saturates; the risk follows step * count up to the ceiling, never down.
        if (slot_count_q[slot] != '1) begin
          slot_count_q[slot] = slot_count_q[slot] + 1'b1;
        end
        prod = (CNT_W+RISK_W)'(risk_step_q) * (CNT_W+RISK_W)'(slot_count_q[slot]);
        if (prod > (CNT_W+RISK_W)'(risk_ceil_q)) begin
          prod = (CNT_W+RISK_W)'(risk_ceil_q);
        end
        if (prod > (CNT_W+RISK_W)'(slot_risk_q[slot])) begin
          slot_risk_q[slot] = prod[RISK_W-1:0];
        end
      end
      rep = report(slot_risk_q[slot], slot_count_q[slot], 1'b1, 1'b0);
    end
    return rep;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    // Most new keys start in two narrow bands at both ends of the table, so probe chains
    // grow long and wrap past the last slot.
    if ($urandom_range(9) < 7) begin
      k[7:0] = ($urandom_range(1) != 0 ? 8'hF0 : 8'h00) | 8'($urandom_range(15));
    end
    return k;
  endfunction

  // Drive one command beat after a random gap and record what it must produce.
  task automatic send_cmd(input logic op, input logic [KEY_W-1:0] key, input logic typed,
                          input risk_report_t want);
    risk_report_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.key       <= key;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = apply_to_table(op, key);
    reports_due.push_back(typed ? want : predicted);
  endtask

  // Hold the command channel idle until every outstanding response has come back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Optionally write both registers, then read both back, as one run of bus transfers.
  task automatic program_risk_regs(input bit do_write, input logic [RISK_W-1:0] step,
                                   input logic [RISK_W-1:0] ceil);
    int i;
    logic [REG_IDX_W-1:0] idx;
    logic [RISK_W-1:0] val;
    if (do_write) begin
      for (i = 0; i < 2; i++) begin
        idx = (i == 0) ? REG_RISK_STEP : REG_RISK_CEIL;
        val = (idx == REG_RISK_STEP) ? step : ceil;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_RISK_STEP) begin
          risk_step_q = val;
        end else begin
          risk_ceil_q = val;
        end
      end
    end
    for (i = 0; i < 2; i++) begin
      idx = (i == 0) ? REG_RISK_STEP : REG_RISK_CEIL;
      val = (idx == REG_RISK_STEP) ? risk_step_q : risk_ceil_q;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= APB_ADDR_W'(idx) << 2;
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      if (prdata !== APB_DATA_W'(val)) begin
        $display("%0t: register %0d read expected %0d, got %0d", $time, idx, val, prdata);
        mismatch_count++;
      end
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic: claims of new keys, hits on stored keys, absent queries and noise.
  task automatic run_phase(input int items, input int s_pct, input int r_pct,
                           input logic [RISK_W-1:0] step, input logic [RISK_W-1:0] ceil,
                           input bit fill);
    int i;
    int roll;
    int claim_pct;
    logic op;
    logic [KEY_W-1:0] key;
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    program_risk_regs(1'b1, step, ceil);
    for (i = 0; i < items; i++) begin
      // Halfway through, the sender holds off until the table has answered everything.
      if (i == items / 2) begin
        wait_drained();
      end
      claim_pct = (fill && stored_keys.size() < ENTRIES) ? 60 : 20;
      roll = $urandom_range(99);
      if (roll < claim_pct || stored_keys.size() == 0) begin
        op  = OP_RECORD;
        key = fresh_key();
      end else if (roll < claim_pct + 50) begin
        key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        op  = ($urandom_range(3) != 0) ? OP_RECORD : OP_QUERY;
      end else if (roll < claim_pct + 65) begin
        op  = OP_QUERY;
        key = fresh_key();
      end else begin
        op  = ($urandom_range(1) != 0) ? OP_RECORD : OP_QUERY;
        key = {$urandom, $urandom};
      end
      send_cmd(op, key, 1'b0, '0);
    end
  endtask

  // Response receiver: ready drops at random at the current idle rate.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each response beat with the oldest outstanding expectation.
  always @(posedge clk) begin : rsp_monitor
    risk_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: response beat with no command outstanding", $time);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        if (rsp_ch.risk_level !== want.risk_level) begin
          $display("%0t: risk_level expected %0d, got %0d", $time, want.risk_level,
                   rsp_ch.risk_level);
          mismatch_count++;
        end
        if (rsp_ch.failure_count !== want.failure_count) begin
          $display("%0t: failure_count expected %0d, got %0d", $time, want.failure_count,
                   rsp_ch.failure_count);
          mismatch_count++;
        end
        if (rsp_ch.key_found !== want.key_found) begin
          $display("%0t: key_found expected %0d, got %0d", $time, want.key_found,
                   rsp_ch.key_found);
          mismatch_count++;
        end
        if (rsp_ch.table_full !== want.table_full) begin
          $display("%0t: table_full expected %0d, got %0d", $time, want.table_full,
                   rsp_ch.table_full);
          mismatch_count++;
        end
      end
    end
  end

  // Generous bound on the whole run, including the clearing pass after reset.
  initial begin
    #9_600_000;
    $display("Some tests failed");
    $finish;
  end

  // Main sequence.
  initial begin
    stim_row_t row;
    risk_report_t absent;
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= OP_QUERY;
    cmd_ch.key       <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    mismatch_count = 0;
    send_idle_pct  = 12;
    recv_idle_pct  = 59;
    risk_step_q    = RISK_STEP_RST;
    risk_ceil_q    = RISK_CEIL_RST;
    for (int s = 0; s < ENTRIES; s++) begin
      slot_key_q[s]   = '0;
      slot_count_q[s] = '0;
      slot_risk_q[s]  = '0;
    end
    absent = '0;

    // Directed rows, starting from the reset register values.
    directed_rows.push_back(cmd_row(OP_QUERY, 64'h0, 1'b1, absent));
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h0, 1'b1,
                                    report(RISK_STEP_RST, 1, 1'b1, 1'b0)));
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h0, 1'b0, '0));
    directed_rows.push_back(cmd_row(OP_QUERY, 64'h0, 1'b0, '0));
    directed_rows.push_back(cmd_row(OP_RECORD, '1, 1'b1,
                                    report(RISK_STEP_RST, 1, 1'b1, 1'b0)));
    // Collides with key zero and moves on to the next slot.
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h100, 1'b1,
                                    report(RISK_STEP_RST, 1, 1'b1, 1'b0)));
    // Starts at the last slot and wraps around past the two taken ones.
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h1FF, 1'b1,
                                    report(RISK_STEP_RST, 1, 1'b1, 1'b0)));
    directed_rows.push_back(cmd_row(OP_QUERY, 64'h2FF, 1'b1, absent));
    directed_rows.push_back(cmd_row(OP_QUERY, 64'h1FF, 1'b0, '0));
    // Repeated hits drive the risk into the ceiling.
    repeat (4) directed_rows.push_back(cmd_row(OP_RECORD, 64'h0, 1'b0, '0));
    directed_rows.push_back(cfg_row(16'hFFFF, 16'h0000));
    // A zero ceiling must not lower a stored risk.
    directed_rows.push_back(cmd_row(OP_RECORD, '1, 1'b0, '0));
    // A new slot takes the full step even above the ceiling.
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h8000_0000_0000_0005, 1'b1,
                                    report(16'hFFFF, 1, 1'b1, 1'b0)));
    directed_rows.push_back(cfg_row(16'h0000, 16'hFFFF));
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h8000_0000_0000_0005, 1'b0, '0));
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h5555_5555_5555_5555, 1'b1,
                                    report(16'h0000, 1, 1'b1, 1'b0)));
    directed_rows.push_back(cfg_row(16'hFFFF, 16'hFFFF));
    directed_rows.push_back(cmd_row(OP_RECORD, 64'h5555_5555_5555_5555, 1'b0, '0));
    directed_rows.push_back(cmd_row(OP_QUERY, 64'h5555_5555_5555_5555, 1'b0, '0));
    directed_rows.push_back(cmd_row(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, absent));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    program_risk_regs(1'b0, '0, '0);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        program_risk_regs(1'b1, row.step, row.ceil);
      end else begin
        send_cmd(row.op, row.key, row.typed, row.want);
      end
    end

    // Random phases; the last one fills the table and keeps going while it is full.
    run_phase(300, 12, 59, 16'($urandom_range(1000, 20000)), 16'($urandom), 1'b0);
    run_phase(300, 59, 12, 16'($urandom), 16'hFFFF, 1'b0);
    run_phase(300, 0, 0, 16'h0001, 16'($urandom), 1'b1);

    // Let every response arrive, then watch for stray beats.
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
